/* src/hmn_pkg.sv */
// Shared types, command codes and the pixel-to-height table for the heightmap normal stream.
package hmn_pkg;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [10:0] MAP_SIZE_RESET = 11'd256;
  localparam int MIN_SIZE = 3;

  // front-to-back job queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [14:0] height_t;  // Q7.8
  typedef logic signed [15:0] diff_t;    // Q8.8 difference of two heights

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] col;
    height_t    height;
    diff_t      dx;
    diff_t      dz;
    logic       last;
  } job_t;

  typedef height_t height_lut_t [256];

  // round_half_up(p * 20480 / 255) - 10240
  function automatic height_lut_t build_height_lut();
    height_lut_t lut;
    for (int p = 0; p < 256; p++) begin
      lut[p] = height_t'((p * 40960 + 255) / 510 - 10240);
    end
    return lut;
  endfunction

  localparam height_lut_t HEIGHT_LUT = build_height_lut();

  function automatic height_t to_height(logic [7:0] p);
    return HEIGHT_LUT[p];
  endfunction

endpackage

/* src/hmn_front.sv */
// Front end: takes transactions, keeps the three-row line store and forms the stencil differences.
module hmn_front
  import hmn_pkg::*;
#(
  parameter int MAX_SIZE = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [10:0]    cfg_data,
  input  logic           in_push,
  output logic           in_full,
  input  logic           in_cmd,
  input  logic [7:0]     in_pixel,
  input  logic [QCW-1:0] q_cnt,
  output logic           job_valid,
  output job_t           job
);

  localparam int CW    = $clog2(MAX_SIZE);
  localparam int NW    = ($clog2(MAX_SIZE + 1) > 11) ? $clog2(MAX_SIZE + 1) : 11;
  localparam int DEPTH = 3 * MAX_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = QCW + 1;

  function automatic logic [1:0] inc3(logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] dec3(logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [AW-1:0] mem_addr(logic [1:0] slot, logic [CW-1:0] col);
    return AW'(slot) * AW'(MAX_SIZE) + AW'(col);
  endfunction

  logic [10:0]   map_size_r;
  logic [CW-1:0] row_r, col_r;
  logic [NW-1:0] drain_col_r;
  logic          draining_r;
  logic [1:0]    slot_r;

  logic [NW-1:0] map_ext, n;
  logic          accept, is_pix, is_drn, job0;
  logic [CW-1:0] j_row, j_col, col_rt;
  logic [1:0]    slot_j, slot_up;
  logic          has_up, has_right, down_zero, j_last;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_up_r, rd_rt_r;
  logic [7:0]    col0_r [3];

  logic          f1_valid_r;
  logic [CW-1:0] f1_row_r, f1_col_r;
  logic [1:0]    f1_slot_r;
  logic          f1_c0_r, f1_up_r, f1_rt_r, f1_dzero_r, f1_last_r;
  logic [7:0]    f1_down_r;
  height_t       prev_center_r, prev_right_r;
  height_t       h_center, h_left, h_right, h_up, h_down;

  assign map_ext = NW'(map_size_r);
  assign n = (map_ext < NW'(MIN_SIZE)) ? NW'(MIN_SIZE) :
             (map_ext > NW'(MAX_SIZE)) ? NW'(MAX_SIZE) : map_ext;

  assign in_full = (FW'(q_cnt) + FW'(f1_valid_r)) >= FW'(QUEUE_DEPTH);
  assign accept  = in_push && !in_full;
  assign is_pix  = accept && (in_cmd == CMD_PIXEL) && !draining_r;
  assign is_drn  = accept && (in_cmd == CMD_DRAIN) && draining_r && (drain_col_r < n);
  assign job0    = (is_pix && (row_r != '0)) || is_drn;

  // pixel (r,c) releases the result for (r-1,c); a drain releases row n-1
  assign j_row     = is_pix ? row_r - CW'(1) : CW'(n - NW'(1));
  assign j_col     = is_pix ? col_r : drain_col_r[CW-1:0];
  assign slot_j    = is_pix ? dec3(slot_r) : slot_r;
  assign slot_up   = dec3(slot_j);
  assign has_up    = (j_row != '0);
  assign has_right = (NW'(j_col) + NW'(1)) < n;
  assign col_rt    = j_col + CW'(1);
  assign down_zero = !is_pix || (NW'(row_r) >= n);
  assign j_last    = is_drn && (drain_col_r == n - NW'(1));

  // line store: one write, two registered reads (row above, right neighbor)
  always_ff @(posedge clk) begin
    if (is_pix) begin
      mem[mem_addr(slot_r, col_r)] <= in_pixel;
    end
    rd_up_r <= mem[mem_addr(slot_up, j_col)];
    rd_rt_r <= mem[mem_addr(slot_j, col_rt)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_size_r  <= MAP_SIZE_RESET;
      row_r       <= '0;
      col_r       <= '0;
      drain_col_r <= '0;
      draining_r  <= 1'b0;
      slot_r      <= 2'd0;
      f1_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        map_size_r <= cfg_data;
      end
      f1_valid_r <= job0;
      if (is_pix) begin
        if ((NW'(col_r) + NW'(1)) >= n) begin
          col_r <= '0;
          if ((NW'(row_r) + NW'(1)) >= n) begin
            draining_r  <= 1'b1;
            drain_col_r <= '0;
          end else begin
            row_r  <= row_r + CW'(1);
            slot_r <= inc3(slot_r);
          end
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
      if (is_drn) begin
        drain_col_r <= drain_col_r + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_pix && (col_r == '0)) begin
      col0_r[slot_r] <= in_pixel;
    end
    if (job0) begin
      f1_row_r   <= j_row;
      f1_col_r   <= j_col;
      f1_slot_r  <= slot_j;
      f1_c0_r    <= (j_col == '0);
      f1_up_r    <= has_up;
      f1_rt_r    <= has_right;
      f1_dzero_r <= down_zero;
      f1_down_r  <= in_pixel;
      f1_last_r  <= j_last;
    end
    if (f1_valid_r) begin
      prev_center_r <= h_center;
      prev_right_r  <= h_right;
    end
  end

  // sliding window along the row: past column 0, center and left come from earlier right reads
  assign h_center = f1_c0_r ? to_height(col0_r[f1_slot_r]) : prev_right_r;
  assign h_left   = f1_c0_r ? '0 : prev_center_r;
  assign h_right  = f1_rt_r ? to_height(rd_rt_r) : '0;
  assign h_up     = f1_up_r ? to_height(rd_up_r) : '0;
  assign h_down   = f1_dzero_r ? '0 : to_height(f1_down_r);

  assign job_valid  = f1_valid_r;
  assign job.row    = 10'(f1_row_r);
  assign job.col    = 10'(f1_col_r);
  assign job.height = h_center;
  assign job.dx     = diff_t'(h_up) - diff_t'(h_down);
  assign job.dz     = diff_t'(h_left) - diff_t'(h_right);
  assign job.last   = f1_last_r;

endmodule

/* src/hmn_queue.sv */
// Short job queue between the front end and the normalize pipeline.
module hmn_queue
  import hmn_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  job_t           push_data,
  input  logic           pop,
  output job_t           pop_data,
  output logic           empty,
  output logic [QCW-1:0] count
);

  job_t           entries_r [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] cnt_r;

  assign pop_data = entries_r[rd_ptr_r];
  assign empty    = (cnt_r == '0);
  assign count    = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPW'(1);
      end
      cnt_r <= cnt_r + QCW'(push) - QCW'(pop);
    end
  end

endmodule

/* src/hmn_back.sv */
// Back end: normalize pipeline (squares, long division, square root) and result register.
module hmn_back
  import hmn_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_empty,
  input  job_t                job_data,
  output logic                job_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [9:0]          out_row,
  output logic [9:0]          out_col,
  output logic signed [14:0]  out_height,
  output logic signed [15:0]  out_normal_x,
  output logic signed [15:0]  out_normal_y,
  output logic signed [15:0]  out_normal_z,
  output logic                out_last
);

  localparam int DIV_STEPS  = 30;
  localparam int SQRT_STEPS = 15;
  localparam int STAGES     = 1 + DIV_STEPS + SQRT_STEPS;
  localparam logic [29:0] Q_TWO_SQ = 30'd262144;  // 2.0 in Q7.8, squared

  // rem/q hold remainder and quotient during division, then radicand and root
  typedef struct packed {
    logic [9:0]  row;
    logic [9:0]  col;
    height_t     height;
    logic        last;
    logic        neg_x;
    logic        neg_z;
    logic [29:0] s;
    logic [29:0] rem_x;
    logic [29:0] rem_y;
    logic [29:0] rem_z;
    logic [29:0] q_x;
    logic [29:0] q_y;
    logic [29:0] q_z;
  } pipe_t;

  function automatic logic [59:0] div_step(logic [29:0] rem, logic [29:0] q, logic [29:0] s);
    logic [30:0] r2;
    logic [30:0] diff;
    r2   = {rem, 1'b0};
    diff = r2 - {1'b0, s};
    if (r2 >= {1'b0, s}) begin
      return {diff[29:0], q[28:0], 1'b1};
    end
    return {r2[29:0], q[28:0], 1'b0};
  endfunction

  function automatic logic [59:0] sqrt_step(logic [29:0] op, logic [29:0] res, input int k);
    logic [29:0] one;
    logic [29:0] trial;
    one   = 30'd1 << (28 - 2 * k);
    trial = res + one;
    if (op >= trial) begin
      return {op - trial, (res >> 1) + one};
    end
    return {op, res >> 1};
  endfunction

  function automatic logic signed [15:0] unit_out(logic [29:0] root, logic neg);
    logic [15:0] mid;
    mid = (root[15:0] + 16'd1) >> 1;
    return neg ? -$signed(mid) : $signed(mid);
  endfunction

  pipe_t               st_r [STAGES];
  logic [STAGES-1:0]   vld_r;
  logic                en;
  logic                out_valid_r;
  pipe_t               st0;
  logic signed [31:0]  px, pz;

  // whole pipeline advances unless a finished result sits unread
  assign en      = !out_valid_r || out_pop;
  assign job_pop = en && !job_empty;

  assign px = job_data.dx * job_data.dx;
  assign pz = job_data.dz * job_data.dz;

  always_comb begin
    st0        = '0;
    st0.row    = job_data.row;
    st0.col    = job_data.col;
    st0.height = job_data.height;
    st0.last   = job_data.last;
    st0.neg_x  = job_data.dx[15];
    st0.neg_z  = job_data.dz[15];
    st0.s      = px[29:0] + pz[29:0] + Q_TWO_SQ;
    st0.rem_x  = px[29:0];
    st0.rem_y  = Q_TWO_SQ;
    st0.rem_z  = pz[29:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st0;
    end
  end

  for (genvar g = 1; g < STAGES; g++) begin : g_stage
    pipe_t nxt;
    always_comb begin
      nxt = st_r[g-1];
      if (g <= DIV_STEPS) begin
        {nxt.rem_x, nxt.q_x} = div_step(st_r[g-1].rem_x, st_r[g-1].q_x, st_r[g-1].s);
        {nxt.rem_y, nxt.q_y} = div_step(st_r[g-1].rem_y, st_r[g-1].q_y, st_r[g-1].s);
        {nxt.rem_z, nxt.q_z} = div_step(st_r[g-1].rem_z, st_r[g-1].q_z, st_r[g-1].s);
      end else if (g == DIV_STEPS + 1) begin
        {nxt.rem_x, nxt.q_x} = sqrt_step(st_r[g-1].q_x, '0, 0);
        {nxt.rem_y, nxt.q_y} = sqrt_step(st_r[g-1].q_y, '0, 0);
        {nxt.rem_z, nxt.q_z} = sqrt_step(st_r[g-1].q_z, '0, 0);
      end else begin
        {nxt.rem_x, nxt.q_x} = sqrt_step(st_r[g-1].rem_x, st_r[g-1].q_x, g - 1 - DIV_STEPS);
        {nxt.rem_y, nxt.q_y} = sqrt_step(st_r[g-1].rem_y, st_r[g-1].q_y, g - 1 - DIV_STEPS);
        {nxt.rem_z, nxt.q_z} = sqrt_step(st_r[g-1].rem_z, st_r[g-1].q_z, g - 1 - DIV_STEPS);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[STAGES-2:0], job_pop};
      out_valid_r <= vld_r[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[STAGES-1]) begin
      out_row      <= st_r[STAGES-1].row;
      out_col      <= st_r[STAGES-1].col;
      out_height   <= st_r[STAGES-1].height;
      out_last     <= st_r[STAGES-1].last;
      out_normal_x <= unit_out(st_r[STAGES-1].q_x, st_r[STAGES-1].neg_x);
      out_normal_y <= unit_out(st_r[STAGES-1].q_y, 1'b0);
      out_normal_z <= unit_out(st_r[STAGES-1].q_z, st_r[STAGES-1].neg_z);
    end
  end

  assign out_empty = !out_valid_r;

endmodule

/* src/heightmap_to_normal_stream.sv */
// Top level: heightmap in, per-sample height and unit normal out.
// Path from an accepted transaction to its result: line store read,
//   window stage, job queue, 46-stage normalize pipeline, result register.
// Throughput: one transaction per cycle while results are popped, set by the two-read
//   line store and the pipelined division and square-root stages; else in_full holds input.
// Reset (rst_n low, synchronous) clears counters, queues and pipeline valids; map_size
//   returns to 256. The line store is not cleared; every entry is written before use.
module heightmap_to_normal_stream
  import hmn_pkg::*;
#(
  parameter int MAX_SIZE = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_data,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_cmd,
  input  logic [7:0]         in_pixel,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [9:0]         out_row,
  output logic [9:0]         out_col,
  output logic signed [14:0] out_height,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic               out_last
);

  // front -> queue
  logic           job_valid;
  job_t           job;
  // queue -> back
  job_t           q_data;
  logic           q_empty, q_pop;
  logic [QCW-1:0] q_cnt;

  // Front reserves a queue slot for each job in flight, so it never overruns.
  hmn_front #(
    .MAX_SIZE (MAX_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_cmd    (in_cmd),
    .in_pixel  (in_pixel),
    .q_cnt     (q_cnt),
    .job_valid (job_valid),
    .job       (job)
  );

  hmn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_valid),
    .push_data (job),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .count     (q_cnt)
  );

  // Back stalls as a whole only while an unread result is held.
  hmn_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_empty    (q_empty),
    .job_data     (q_data),
    .job_pop      (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_height   (out_height),
    .out_normal_x (out_normal_x),
    .out_normal_y (out_normal_y),
    .out_normal_z (out_normal_z),
    .out_last     (out_last)
  );

endmodule

/* sim/heightmap_to_normal_stream_tb.sv */
// Testbench for heightmap_to_normal_stream: one random map streamed through, checked by a scoreboard.
`timescale 1ns / 1ps

module heightmap_to_normal_stream_tb
  import hmn_pkg::*;
();

  localparam int MAX_SIDE    = 1024;
  localparam int SIDE        = 40;       // final side: ~1600 pixel transactions
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_TAIL  = 60;       // cycles after the last result

  // One predicted or observed result transaction.
  typedef struct {
    logic [9:0]         row;
    logic [9:0]         col;
    logic signed [14:0] height;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               last;
  } normal_rec_t;

  // Tracks the map as the block should see it and queues the normals it must produce.
  class normal_scoreboard;
    byte unsigned rows3 [3 * MAX_SIDE];
    int unsigned  cur_row, cur_col, flush_col, side_reg;
    bit           flushing;
    normal_rec_t  pending_normals [$];
    int           errors;

    function new();
      cur_row = 0; cur_col = 0; flush_col = 0; flushing = 0;
      side_reg = 32'(MAP_SIZE_RESET); errors = 0;
    endfunction

    function void set_size(logic [10:0] v);
      side_reg = 32'(v);
    endfunction

    function int unsigned eff_side();
      if (side_reg < MIN_SIZE) return MIN_SIZE;
      if (side_reg > MAX_SIDE) return MAX_SIDE;
      return side_reg;
    endfunction

    // Q7.8 height, rounded half up.
    function int q_height(int unsigned p);
      return int'((p * 40960 + 255) / 510) - 10240;
    endfunction

    function int at(int unsigned r, int unsigned c);
      if (c >= MAX_SIDE) return 0;
      return q_height(rows3[(r % 3) * MAX_SIDE + c]);
    endfunction

    // Rounded |v|*16384/sqrt(s), halves away from zero, sign restored.
    function int unit_q14(int v, longint unsigned s);
      longint unsigned mag, t2, d;
      int unsigned lo, hi, mid;
      mag = (v < 0) ? longint'(-v) : longint'(v);
      t2 = (mag * 32768) * (mag * 32768);
      lo = 0; hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        d = 2 * longint'(mid) - 1;
        if (d * d * s <= t2) lo = mid; else hi = mid - 1;
      end
      return (v < 0) ? -int'(lo) : int'(lo);
    endfunction

    function void predict(int unsigned r, int unsigned c, int below, bit is_last);
      int unsigned n;
      int above, lft, rgt, dx, dz;
      longint unsigned s;
      normal_rec_t e;
      n = eff_side();
      above = (r >= 1) ? at(r - 1, c) : 0;
      lft = (c >= 1) ? at(r, c - 1) : 0;
      rgt = (c + 1 < n) ? at(r, c + 1) : 0;
      dx = above - below;
      dz = lft - rgt;
      s = longint'(dx) * dx + 512 * 512 + longint'(dz) * dz;
      e.row = r[9:0]; e.col = c[9:0];
      e.height = 15'(at(r, c));
      e.nx = 16'(unit_q14(dx, s));
      e.ny = 16'(unit_q14(512, s));
      e.nz = 16'(unit_q14(dz, s));
      e.last = is_last;
      pending_normals.insert(pending_normals.size(), e);
    endfunction

    function void note_input(logic cmd, logic [7:0] pix);
      int unsigned n;
      n = eff_side();
      if (cmd == CMD_PIXEL) begin
        if (flushing) return;
        if (cur_col < MAX_SIDE) rows3[(cur_row % 3) * MAX_SIDE + cur_col] = pix;
        if (cur_row >= 1)
          predict(cur_row - 1, cur_col, (cur_row < n) ? q_height(pix) : 0, 1'b0);
        if (cur_col + 1 >= n) begin
          cur_col = 0;
          if (cur_row + 1 >= n) begin
            flushing = 1;
            flush_col = 0;
          end else begin
            cur_row++;
          end
        end else begin
          cur_col++;
        end
      end else begin
        if (!flushing || flush_col >= n) return;
        predict(n - 1, flush_col, 0, flush_col == n - 1);
        flush_col++;
      end
    endfunction

    function void check(normal_rec_t got);
      normal_rec_t e;
      if (pending_normals.size() == 0) begin
        $error("unexpected result row=%0d col=%0d", got.row, got.col);
        errors++;
        return;
      end
      e = pending_normals.pop_front();
      if (got.row !== e.row) begin
        $error("row: expected %0d, got %0d", e.row, got.row); errors++;
      end
      if (got.col !== e.col) begin
        $error("col: expected %0d, got %0d", e.col, got.col); errors++;
      end
      if (got.height !== e.height) begin
        $error("height: expected %0d, got %0d", e.height, got.height); errors++;
      end
      if (got.nx !== e.nx) begin
        $error("normal_x: expected %0d, got %0d", e.nx, got.nx); errors++;
      end
      if (got.ny !== e.ny) begin
        $error("normal_y: expected %0d, got %0d", e.ny, got.ny); errors++;
      end
      if (got.nz !== e.nz) begin
        $error("normal_z: expected %0d, got %0d", e.nz, got.nz); errors++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [10:0]        cfg_data;
  logic               in_push;
  logic               in_full;
  logic               in_cmd;
  logic [7:0]         in_pixel;
  logic               out_empty;
  logic               out_pop;
  logic [9:0]         out_row;
  logic [9:0]         out_col;
  logic signed [14:0] out_height;
  logic signed [15:0] out_normal_x;
  logic signed [15:0] out_normal_y;
  logic signed [15:0] out_normal_z;
  logic               out_last;

  normal_scoreboard sb = new();
  bit               steady;   // when set, neither side idles
  int               cycles;

  heightmap_to_normal_stream i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_cmd      (in_cmd),
    .in_pixel    (in_pixel),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_height  (out_height),
    .out_normal_x(out_normal_x),
    .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z),
    .out_last    (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Pixel values: extremes, single-bit steps and plain random.
  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'(1 << $urandom_range(0, 7));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one input transaction and returns at the edge that takes it.
  task automatic send(logic cmd, logic [7:0] pix);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push  <= 1'b1;
    in_cmd   <= cmd;
    in_pixel <= pix;
    do @(posedge clk); while (in_full);
  endtask

  task automatic write_size(logic [10:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  // Monitors: sample pre-edge values of every handshake.
  always @(posedge clk) begin
    normal_rec_t got;
    if (rst_n) begin
      if (cfg_we) sb.set_size(cfg_data);
      if (in_push && !in_full) sb.note_input(in_cmd, in_pixel);
      if (out_pop && !out_empty) begin
        got.row = out_row; got.col = out_col; got.height = out_height;
        got.nx = out_normal_x; got.ny = out_normal_y; got.nz = out_normal_z;
        got.last = out_last;
        sb.check(got);
      end
    end
  end

  // Result side: pop bursts separated by random stalls.
  initial begin
    int gap;
    out_pop <= 1'b0;
    @(posedge clk);
    forever begin
      gap = idle_len();
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[heightmap_to_normal_stream] ERROR");
      $finish;
    end
  end

  initial begin
    int row_idx;
    steady   = 0;
    rst_n    <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    in_push  <= 1'b0;
    in_cmd   <= CMD_PIXEL;
    in_pixel <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Side register at its extremes, then the side used for the map.
    write_size(11'd0);
    write_size(11'd2047);
    write_size(11'd3);
    write_size(11'd1024);
    write_size(11'(SIDE));

    // Drains before the map is complete produce nothing.
    send(CMD_DRAIN, 8'hff);
    send(CMD_DRAIN, 8'h00);

    // First two rows alternate full-scale extremes for the steepest slopes.
    for (int i = 0; i < SIDE * SIDE; i++) begin
      row_idx = i / SIDE;
      steady = (row_idx >= 10 && row_idx < 14);
      if (row_idx < 2) send(CMD_PIXEL, (i % 2) ? 8'd255 : 8'd0);
      else send(CMD_PIXEL, pick_pixel());
      // stray drains mid-map are ignored
      if ($urandom_range(0, 49) == 0) send(CMD_DRAIN, pick_pixel());
    end
    steady = 0;

    // Pixels past the end of the map are ignored.
    repeat (5) send(CMD_PIXEL, pick_pixel());
    // Flush the last row, then a few drains with nothing left.
    repeat (SIDE + 4) send(CMD_DRAIN, pick_pixel());
    in_push <= 1'b0;

    while (sb.pending_normals.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (sb.errors == 0) begin
      $display("[heightmap_to_normal_stream] OK");
    end else begin
      $display("[heightmap_to_normal_stream] ERROR");
    end
    $finish;
  end

endmodule
